// ===== src/b64d_pkg.sv =====
`default_nettype none

package b64d_pkg;

    localparam int QueueDepth = 2;
    localparam int PtrWidth   = $clog2(QueueDepth);
    localparam int CountWidth = $clog2(QueueDepth + 1);

    // Character classes as seen by the decode stage
    typedef enum logic [1:0] {
        KIND_END  = 2'd0,
        KIND_DATA = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_SKIP = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [5:0] sextet;
    } item_t;

    // One-hot position of the next sextet in its group of four
    typedef enum logic [3:0] {
        PH_FIRST  = 4'b0001,
        PH_SECOND = 4'b0010,
        PH_THIRD  = 4'b0100,
        PH_FOURTH = 4'b1000
    } phase_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

endpackage

`default_nettype wire

// ===== src/b64d_front.sv =====
`default_nettype none

module b64d_front (
    input  wire logic           in_valid,
    input  wire logic [7:0]     in_char,
    input  wire logic           queue_full,
    output logic                in_stall,
    output b64d_pkg::push_t     push
);
    import b64d_pkg::*;

    item_t cls;

    always_comb
    begin
        cls.kind   = KIND_BAD;
        cls.sextet = 6'd0;
        if (in_char == 8'h00)
        begin
            cls.kind = KIND_END;
        end
        else if (in_char <= 8'h20 || in_char >= 8'h7f)
        begin
            cls.kind = KIND_SKIP;
        end
        else if (in_char >= 8'h41 && in_char <= 8'h5a)
        begin
            cls.kind   = KIND_DATA;
            cls.sextet = 6'(in_char - 8'h41);
        end
        else if (in_char >= 8'h61 && in_char <= 8'h7a)
        begin
            cls.kind   = KIND_DATA;
            cls.sextet = 6'(in_char - 8'h61 + 8'd26);
        end
        else if (in_char >= 8'h30 && in_char <= 8'h39)
        begin
            cls.kind   = KIND_DATA;
            cls.sextet = 6'(in_char - 8'h30 + 8'd52);
        end
        else if (in_char == 8'h2b)
        begin
            cls.kind   = KIND_DATA;
            cls.sextet = 6'd62;
        end
        else if (in_char == 8'h2f)
        begin
            cls.kind   = KIND_DATA;
            cls.sextet = 6'd63;
        end
    end

    assign in_stall = queue_full;

    // skipped bytes never reach the queue
    assign push.valid = in_valid && !queue_full && (cls.kind != KIND_SKIP);
    assign push.item  = cls;

endmodule

`default_nettype wire

// ===== src/b64d_queue.sv =====
`default_nettype none

module b64d_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire b64d_pkg::push_t  push,
    input  wire logic             pop,
    output logic                  full,
    output logic                  head_valid,
    output b64d_pkg::item_t       head
);
    import b64d_pkg::*;

    item_t                 entry_reg [QueueDepth];
    logic [PtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic                  do_pop;

    assign full       = (count_reg == CountWidth'(QueueDepth));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.valid && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

`default_nettype wire

// ===== src/b64d_back.sv =====
`default_nettype none

module b64d_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head_valid,
    input  wire b64d_pkg::item_t  head,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [7:0]            out_byte,
    output logic                  end_of_text
);
    import b64d_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [5:0] held_reg, held_next;
    logic       halted_reg, halted_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       eot_reg, eot_next;
    logic       emit;
    logic [5:0] v;

    // result register free, or its transfer completes this cycle
    assign pop = head_valid && (!out_valid_reg || !out_stall);
    assign v   = head.sextet;

    always_comb
    begin
        phase_next    = phase_reg;
        held_next     = held_reg;
        halted_next   = halted_reg;
        out_byte_next = out_byte_reg;
        eot_next      = eot_reg;
        emit          = 1'b0;
        if (pop)
        begin
            unique case (head.kind)
                KIND_END:
                begin
                    emit          = 1'b1;
                    out_byte_next = 8'h00;
                    eot_next      = 1'b1;
                    phase_next    = PH_FIRST;
                    held_next     = 6'd0;
                    halted_next   = 1'b0;
                end
                KIND_BAD:
                begin
                    halted_next = 1'b1;
                end
                KIND_DATA:
                begin
                    if (!halted_reg)
                    begin
                        held_next = v;
                        eot_next  = 1'b0;
                        unique case (phase_reg)
                            PH_FIRST:
                            begin
                                phase_next = PH_SECOND;
                            end
                            PH_SECOND:
                            begin
                                emit          = 1'b1;
                                out_byte_next = {held_reg, v[5:4]};
                                phase_next    = PH_THIRD;
                            end
                            PH_THIRD:
                            begin
                                emit          = 1'b1;
                                out_byte_next = {held_reg[3:0], v[5:2]};
                                phase_next    = PH_FOURTH;
                            end
                            PH_FOURTH:
                            begin
                                emit          = 1'b1;
                                out_byte_next = {held_reg[1:0], v};
                                phase_next    = PH_FIRST;
                            end
                            default:
                            begin
                                phase_next = PH_FIRST;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
        out_valid_next = emit ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            held_reg      <= 6'd0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        eot_reg      <= eot_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign end_of_text = eot_reg;

endmodule

`default_nettype wire

// ===== src/base64_stream_decoder.sv =====
// Streaming base64 decoder: one text byte per transfer in, one decoded byte
// (or an end-of-text marker for a zero byte) per transfer out. Bytes are taken
// at one per clock while the queue has room; each passes through a two-entry queue
// of classified characters and then the result register before it transfers out.
// The input stalls only when both queue entries are held, which happens while
// the output side stalls with a result pending. Whitespace and other control
// or high bytes are dropped; any other non-alphabet byte, '=' included, stops
// decoding until the next zero byte.
`default_nettype none

module base64_stream_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_char,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            end_of_text
);
    import b64d_pkg::*;

    push_t push;
    item_t head;
    logic  queue_full;
    logic  head_valid;
    logic  pop;

    b64d_front u_front (
        .in_valid   (in_valid),
        .in_char    (in_char),
        .queue_full (queue_full),
        .in_stall   (in_stall),
        .push       (push)
    );

    b64d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    b64d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .end_of_text (end_of_text)
    );

    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        queue_full |-> head_valid)
        else $error("queue full but no head entry");

    a_full_from_held: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(queue_full) |-> $past(head_valid) && $past(push.valid) && !$past(pop))
        else $error("queue filled without a held entry");

    a_eot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_text |-> out_byte == 8'h00)
        else $error("terminator with nonzero byte");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid && (!out_valid || !out_stall))
        else $error("pop while result register blocked");

endmodule

`default_nettype wire

// ===== test/tb_base64_stream_decoder.sv =====
`timescale 1ns / 100ps

module tb_base64_stream_decoder;

    import b64d_pkg::*;

    localparam int          WatchdogLimit = 2000;
    localparam int          TargetItems   = 1500;
    localparam int          DrainCycles   = 8;
    localparam logic [7:0]  CH_END        = 8'h00;
    localparam logic [7:0]  CH_SPACE      = 8'h20;
    localparam logic [7:0]  CH_DEL        = 8'h7F;
    localparam logic [7:0]  CH_PAD        = "=";

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } byte_result_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fixed;
        logic [7:0] want_byte;
        logic       want_eot;
    } text_row_t;

    // Fixed rows carry the result that is obvious by eye; the rest go through the decoder model
    localparam int ScriptLen = 26;
    localparam text_row_t TEXT_SCRIPT [0:ScriptLen-1] = '{
        '{CH_END,   1'b1, 8'h00, 1'b1},
        '{"/",      1'b0, 8'h00, 1'b0},
        '{"/",      1'b1, 8'hFF, 1'b0},
        '{"/",      1'b1, 8'hFF, 1'b0},
        '{"/",      1'b1, 8'hFF, 1'b0},
        '{"A",      1'b0, 8'h00, 1'b0},
        '{"A",      1'b1, 8'h00, 1'b0},
        '{"A",      1'b1, 8'h00, 1'b0},
        '{"A",      1'b1, 8'h00, 1'b0},
        '{"Z",      1'b0, 8'h00, 1'b0},
        '{"m",      1'b0, 8'h00, 1'b0},
        '{CH_SPACE, 1'b0, 8'h00, 1'b0},
        '{"9",      1'b0, 8'h00, 1'b0},
        '{CH_DEL,   1'b0, 8'h00, 1'b0},
        '{"v",      1'b0, 8'h00, 1'b0},
        '{8'hFF,    1'b0, 8'h00, 1'b0},
        '{8'h01,    1'b0, 8'h00, 1'b0},
        '{"Q",      1'b0, 8'h00, 1'b0},
        '{"Q",      1'b0, 8'h00, 1'b0},
        '{CH_PAD,   1'b0, 8'h00, 1'b0},
        '{"A",      1'b0, 8'h00, 1'b0},
        '{CH_END,   1'b1, 8'h00, 1'b1},
        '{"Q",      1'b0, 8'h00, 1'b0},
        '{"-",      1'b0, 8'h00, 1'b0},
        '{8'h80,    1'b0, 8'h00, 1'b0},
        '{CH_END,   1'b1, 8'h00, 1'b1}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_char = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       end_of_text;

    // decoder model state
    logic [1:0]   dec_phase = 2'd0;
    logic [5:0]   dec_held = 6'd0;
    logic         dec_halted = 1'b0;

    byte_result_t decoded_q [$];
    int           error_count = 0;
    int           sent_total = 0;
    int           burst_left = 0;
    int           idle_cycles = 0;
    int unsigned  stall_cycle = 0;

    base64_stream_decoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_char     (in_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .end_of_text (end_of_text)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic kind_t classify_char(input logic [7:0] ch, output logic [5:0] sx);
        sx = 6'd0;
        if (ch == CH_END)
            return KIND_END;
        if (ch <= CH_SPACE || ch >= CH_DEL)
            return KIND_SKIP;
        if (ch >= "A" && ch <= "Z")
            sx = 6'(ch - "A");
        else if (ch >= "a" && ch <= "z")
            sx = 6'(ch - "a" + 26);
        else if (ch >= "0" && ch <= "9")
            sx = 6'(ch - "0" + 52);
        else if (ch == "+")
            sx = 6'd62;
        else if (ch == "/")
            sx = 6'd63;
        else
            return KIND_BAD;
        return KIND_DATA;
    endfunction

    function automatic logic [7:0] alphabet_char(input int idx);
        if (idx < 26)
            return 8'("A" + idx);
        if (idx < 52)
            return 8'("a" + idx - 26);
        if (idx < 62)
            return 8'("0" + idx - 52);
        return (idx == 62) ? "+" : "/";
    endfunction

    // Advances the decoder model by one character
    function automatic void decode_char(input logic [7:0] ch, output logic has_out,
                                        output byte_result_t res);
        logic [5:0] sx;
        kind_t      kind;
        kind = classify_char(ch, sx);
        has_out = 1'b0;
        res = '0;
        if (kind == KIND_END)
        begin
            has_out = 1'b1;
            res.eot = 1'b1;
            dec_phase = 2'd0;
            dec_held = 6'd0;
            dec_halted = 1'b0;
        end
        else if (dec_halted || kind == KIND_SKIP)
            has_out = 1'b0;
        else if (kind == KIND_BAD)
            dec_halted = 1'b1;
        else
        begin
            case (dec_phase)
                2'd1: res.data = {dec_held, sx[5:4]};
                2'd2: res.data = {dec_held[3:0], sx[5:2]};
                2'd3: res.data = {dec_held[1:0], sx};
                default: res.data = 8'h00;
            endcase
            has_out = (dec_phase != 2'd0);
            dec_held = sx;
            dec_phase = dec_phase + 2'd1;
        end
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic fixed = 1'b0,
                             input byte_result_t want = '0);
        int           gap;
        logic         has_out;
        byte_result_t res;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ((sent_total / 200) % 3 == 0)
                gap = 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_char <= ch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_total++;
        decode_char(ch, has_out, res);
        if (has_out)
            decoded_q.push_back(fixed ? want : res);
    endtask

    task automatic send_text(input bit broken);
        int         len;
        int         bad_at;
        logic [7:0] junk;
        logic [5:0] sx;
        len = $urandom_range(0, 40);
        bad_at = broken ? $urandom_range(0, len) : -1;
        for (int i = 0; i <= len; i++)
        begin
            if (i == bad_at)
            begin
                do
                    junk = 8'($urandom_range(8'h21, 8'h7E));
                while (classify_char(junk, sx) == KIND_DATA);
                send_char(junk);
            end
            if (i == len)
                break;
            if ($urandom_range(0, 9) == 0)
                send_char($urandom_range(0, 1) ? 8'($urandom_range(1, 8'h20))
                                                : 8'($urandom_range(8'h7F, 8'hFF)));
            else
                send_char(alphabet_char($urandom_range(0, 63)));
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_char(CH_PAD);
        if ($urandom_range(0, 15) != 0)
            send_char(CH_END);
    endtask

    // receiver back-pressure, changing its character with bits 9:8 of a free-running cycle counter
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        case ((stall_cycle >> 8) % 4)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ((stall_cycle % 7) < 3);
        endcase
    end

    // outputs and stall only move at the rising edge, so the negedge sees the transfer to come
    always @(negedge clk)
    begin
        byte_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_q.size() == 0)
                report_mismatch($sformatf("unexpected transfer byte=%02h eot=%0b",
                                          out_byte, end_of_text));
            else
            begin
                want = decoded_q.pop_front();
                if (out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_byte, want.data));
                if (end_of_text !== want.eot)
                    report_mismatch($sformatf("end_of_text %0b, expected %0b",
                                              end_of_text, want.eot));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("Timeout: no transfer for %0d cycles", WatchdogLimit);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int sel;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < ScriptLen; i++)
            send_char(TEXT_SCRIPT[i].ch, TEXT_SCRIPT[i].fixed,
                      '{TEXT_SCRIPT[i].want_byte, TEXT_SCRIPT[i].want_eot});

        while (sent_total < TargetItems)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
                send_text(1'b0);
            else if (sel < 9)
                send_text(1'b1);
            else
                repeat ($urandom_range(1, 20)) send_char(8'($urandom_range(0, 255)));
        end
        in_valid <= 1'b0;

        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (decoded_q.size() != 0)
            report_mismatch("results still outstanding at end of run");

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
